>>> rtl/ece_pkg.sv
// ----------------------------------------------------------------------------
// ece_pkg
// Shared constants of the easing curve evaluator: default widths, curve codes
// and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ece_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int VALUE_BITS = 16;
	localparam int TIME_BITS  = 16;
	localparam int MODE_BITS  = 4;
	localparam int INDEX_BITS = 2;

	localparam logic [MODE_BITS-1:0] MODE_QUAD_IN      = 4'd0;
	localparam logic [MODE_BITS-1:0] MODE_QUAD_OUT     = 4'd1;
	localparam logic [MODE_BITS-1:0] MODE_QUAD_INOUT   = 4'd2;
	localparam logic [MODE_BITS-1:0] MODE_CUBIC_IN     = 4'd3;
	localparam logic [MODE_BITS-1:0] MODE_CUBIC_OUT    = 4'd4;
	localparam logic [MODE_BITS-1:0] MODE_CUBIC_INOUT  = 4'd5;
	localparam logic [MODE_BITS-1:0] MODE_QUINT_IN     = 4'd6;
	localparam logic [MODE_BITS-1:0] MODE_QUINT_OUT    = 4'd7;
	localparam logic [MODE_BITS-1:0] MODE_QUINT_INOUT  = 4'd8;
	localparam logic [MODE_BITS-1:0] MODE_BOUNCE_IN    = 4'd9;
	localparam logic [MODE_BITS-1:0] MODE_BOUNCE_OUT   = 4'd10;
	localparam logic [MODE_BITS-1:0] MODE_BOUNCE_INOUT = 4'd11;

	localparam logic [INDEX_BITS-1:0] REG_MODE     = 2'd0;
	localparam logic [INDEX_BITS-1:0] REG_START    = 2'd1;
	localparam logic [INDEX_BITS-1:0] REG_CHANGE   = 2'd2;
	localparam logic [INDEX_BITS-1:0] REG_DURATION = 2'd3;

endpackage

`default_nettype wire

>>> rtl/easing_curve_evaluator.sv
// Throughput: one word per cycle when the output side does not stall; the
// FRAC_BITS + 1 stage restoring divider and the eight curve stages each hold
// one word, and bubbles close up on stall.
// Reset: clears all valid bits and sets mode 0, start 0, change 0, duration 1.
// ----------------------------------------------------------------------------
// easing_curve_evaluator
// Pipelined easing curve evaluator: normalises the clamped time step to a
// Q1.F fraction, evaluates a polynomial or bounce curve and scales the result.
// ----------------------------------------------------------------------------
`default_nettype none

module easing_curve_evaluator #(
	parameter int FRAC_BITS  = ece_pkg::FRAC_BITS,
	parameter int VALUE_BITS = ece_pkg::VALUE_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  wr_en,
	input  wire logic [ece_pkg::INDEX_BITS-1:0]        wr_index,
	input  wire logic [((VALUE_BITS > ece_pkg::TIME_BITS) ?
		VALUE_BITS : ece_pkg::TIME_BITS)-1:0]      wr_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [ece_pkg::TIME_BITS-1:0]         time_step,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [VALUE_BITS:0]                 eased_value,
	output logic                                       bad_duration
);

	localparam int F    = FRAC_BITS;
	localparam int TW   = ece_pkg::TIME_BITS;
	localparam int MB   = ece_pkg::MODE_BITS;
	localparam int UW   = F + 1;
	localparam int NDIV = F + 1;
	localparam int NS   = NDIV + 8;
	localparam int XW   = F + 5;
	localparam int MW   = XW + 1;
	localparam int AW   = F + 3;
	localparam int MMW  = 2 * AW;
	localparam int PW   = VALUE_BITS + UW + 1;
	localparam int RW   = VALUE_BITS + 2;

	localparam int SA = NDIV;
	localparam int SB = NDIV + 1;
	localparam int SC = NDIV + 2;
	localparam int SD = NDIV + 3;
	localparam int SE = NDIV + 4;
	localparam int SF = NDIV + 5;
	localparam int SG = NDIV + 6;
	localparam int SH = NDIV + 7;

	localparam logic [UW-1:0] ONE  = {1'b1, {F{1'b0}}};
	localparam logic [UW-1:0] HALF = ONE >> 1;

	localparam logic [XW-1:0] ONE_X = {4'b0000, ONE};
	localparam logic [XW-1:0] X4    = ONE_X << 2;
	localparam logic [XW-1:0] X6    = (ONE_X << 2) + (ONE_X << 1);
	localparam logic [XW-1:0] X8    = ONE_X << 3;
	localparam logic [XW-1:0] X9    = (ONE_X << 3) + ONE_X;
	localparam logic [XW-1:0] X10   = (ONE_X << 3) + (ONE_X << 1);
	localparam logic [MW-1:0] X21   = ({1'b0, ONE_X} << 4) + ({1'b0, ONE_X} << 2) +
		{1'b0, ONE_X};

	localparam logic [UW-1:0] LVL2 = ONE - (ONE >> 2);
	localparam logic [UW-1:0] LVL3 = ONE - (ONE >> 4);
	localparam logic [UW-1:0] LVL4 = ONE - (ONE >> 6);

	localparam logic [MMW:0] RND_NEAR = {{(MMW-F-3){1'b0}}, 1'b1, {(F+3){1'b0}}};
	localparam logic [MMW:0] RND_LAST = {{(MMW-F-5){1'b0}}, 1'b1, {(F+5){1'b0}}};

	// Q.F product of two values within 0..ONE, rounded half up
	function automatic logic [UW-1:0] mulq(input logic [UW-1:0] a,
		input logic [UW-1:0] b);
		logic [2*UW-1:0] p;
		p = a * b + {{UW{1'b0}}, HALF};
		return p[F+UW-1:F];
	endfunction

	// ---------------------------------------------------------------- config
	logic [MB-1:0]         mode_q;
	logic [VALUE_BITS-1:0] start_q;
	logic [VALUE_BITS-1:0] change_q;
	logic [TW-1:0]         duration_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= ece_pkg::MODE_QUAD_IN;
			start_q    <= '0;
			change_q   <= '0;
			duration_q <= TW'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				ece_pkg::REG_MODE:     mode_q     <= wr_data[MB-1:0];
				ece_pkg::REG_START:    start_q    <= wr_data[VALUE_BITS-1:0];
				ece_pkg::REG_CHANGE:   change_q   <= wr_data[VALUE_BITS-1:0];
				ece_pkg::REG_DURATION: duration_q <= wr_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ flow control
	logic [NS-1:0] vld_s;
	logic [NS:0]   go;

	assign go[NS] = out_ready;

	for (genvar s = 0; s < NS; s++) begin : g_flow
		// advance a stage when it is empty or the next one moves
		assign go[s] = ~vld_s[s] | go[s+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (go[s]) begin
				if (s == 0) begin
					vld_s[s] <= in_valid;
				end else begin
					vld_s[s] <= vld_s[(s == 0) ? 0 : s-1];
				end
			end
		end
	end

	assign in_ready  = go[0];
	assign out_valid = vld_s[NS-1];

	// ------------------------------------------------------ restoring divider
	logic [TW:0]   dv_rem_s [NDIV];
	logic [UW-1:0] dv_q_s   [NDIV];

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic [TW:0]   rin;
		logic [UW-1:0] qin;
		logic [TW:0]   r1;
		logic          ge;

		if (k == 0) begin : g_first
			assign rin = (time_step > duration_q) ? {1'b0, duration_q} :
				{1'b0, time_step};
			assign qin = '0;
		end else begin : g_next
			assign rin = dv_rem_s[k-1];
			assign qin = dv_q_s[k-1];
		end

		assign ge = (rin >= {1'b0, duration_q});
		assign r1 = ge ? (rin - {1'b0, duration_q}) : rin;

		always_ff @(posedge clk) begin
			if (go[k]) begin
				dv_rem_s[k] <= {r1[TW-1:0], 1'b0};
				dv_q_s[k]   <= {qin[UW-2:0], ge};
			end
		end
	end

	// ----------------------------------------------- stage 1: curve operands
	logic [UW-1:0] u_a, r_a, base_a, xb_a;
	logic [UW:0]   x2_a, fold_a;
	logic          lo_a;

	logic [UW-1:0] base_s1, xb_s1;
	logic          lo_s1;

	always_comb begin
		u_a    = dv_q_s[NDIV-1];
		r_a    = ONE - u_a;
		lo_a   = (u_a < HALF);
		x2_a   = {u_a, 1'b0};
		fold_a = lo_a ? ({1'b0, ONE} - x2_a) : (x2_a - {1'b0, ONE});
		case (mode_q) inside
			ece_pkg::MODE_QUAD_IN, ece_pkg::MODE_CUBIC_IN,
			ece_pkg::MODE_QUINT_IN:    base_a = u_a;
			ece_pkg::MODE_QUAD_OUT, ece_pkg::MODE_CUBIC_OUT,
			ece_pkg::MODE_QUINT_OUT:   base_a = r_a;
			default:                   base_a = lo_a ? u_a : r_a;
		endcase
		case (mode_q)
			ece_pkg::MODE_BOUNCE_IN:    xb_a = r_a;
			ece_pkg::MODE_BOUNCE_INOUT: xb_a = fold_a[UW-1:0];
			default:                    xb_a = u_a;
		endcase
	end

	always_ff @(posedge clk) begin
		if (go[SA]) begin
			base_s1 <= base_a;
			xb_s1   <= xb_a;
			lo_s1   <= lo_a;
		end
	end

	// ------------------------------- stage 2: square, bounce segment choice
	logic [XW-1:0] x11_b;
	logic [MW-1:0] m_b, neg_b;
	logic [UW-1:0] lvl_b;
	logic          seg4_b;

	logic [UW-1:0] p2_s2, base_s2, lvl_s2;
	logic [AW-1:0] am_s2;
	logic          lo_s2, seg4_s2;

	always_comb begin
		x11_b  = ({1'b0, xb_s1, 3'b000}) + ({3'b000, xb_s1, 1'b0}) +
			({4'b0000, xb_s1});
		seg4_b = 1'b0;
		if (x11_b < X4) begin
			m_b   = {1'b0, x11_b};
			lvl_b = '0;
		end else if (x11_b < X8) begin
			m_b   = {1'b0, x11_b} - {1'b0, X6};
			lvl_b = LVL2;
		end else if (x11_b < X10) begin
			m_b   = {1'b0, x11_b} - {1'b0, X9};
			lvl_b = LVL3;
		end else begin
			m_b    = {x11_b, 1'b0} - X21;
			lvl_b  = LVL4;
			seg4_b = 1'b1;
		end
		neg_b = -m_b;
	end

	always_ff @(posedge clk) begin
		if (go[SB]) begin
			p2_s2   <= mulq(base_s1, base_s1);
			base_s2 <= base_s1;
			lo_s2   <= lo_s1;
			am_s2   <= m_b[MW-1] ? neg_b[AW-1:0] : m_b[AW-1:0];
			lvl_s2  <= lvl_b;
			seg4_s2 <= seg4_b;
		end
	end

	// ------------------------------------------ stage 3: cube, bounce square
	logic [UW-1:0]  p3_s3, p2_s3, base_s3, lvl_s3;
	logic [MMW-1:0] mm_s3;
	logic           lo_s3, seg4_s3;

	always_ff @(posedge clk) begin
		if (go[SC]) begin
			p3_s3   <= mulq(p2_s2, base_s2);
			p2_s3   <= p2_s2;
			base_s3 <= base_s2;
			lo_s3   <= lo_s2;
			mm_s3   <= am_s2 * am_s2;
			lvl_s3  <= lvl_s2;
			seg4_s3 <= seg4_s2;
		end
	end

	// ------------------------------- stage 4: fourth power, bounce level add
	logic [MMW:0]  sum_d, sh_d;
	logic [UW:0]   by_d;

	logic [UW-1:0] p4_s4, p3_s4, p2_s4, base_s4, by_s4;
	logic          lo_s4;

	always_comb begin
		if (seg4_s3) begin
			sum_d = {1'b0, mm_s3} + RND_LAST;
			sh_d  = sum_d >> (F + 6);
		end else begin
			sum_d = {1'b0, mm_s3} + RND_NEAR;
			sh_d  = sum_d >> (F + 4);
		end
		by_d = sh_d[UW:0] + {1'b0, lvl_s3};
	end

	always_ff @(posedge clk) begin
		if (go[SD]) begin
			p4_s4   <= mulq(p3_s3, base_s3);
			p3_s4   <= p3_s3;
			p2_s4   <= p2_s3;
			base_s4 <= base_s3;
			lo_s4   <= lo_s3;
			by_s4   <= (by_d > {1'b0, ONE}) ? ONE : by_d[UW-1:0];
		end
	end

	// -------------------------------------------------- stage 5: fifth power
	logic [UW-1:0] p5_s5, p3_s5, p2_s5, by_s5;
	logic          lo_s5;

	always_ff @(posedge clk) begin
		if (go[SE]) begin
			p5_s5 <= mulq(p4_s4, base_s4);
			p3_s5 <= p3_s4;
			p2_s5 <= p2_s4;
			by_s5 <= by_s4;
			lo_s5 <= lo_s4;
		end
	end

	// ---------------------------------------------- stage 6: curve selection
	logic [UW-1:0] pn_f, y_f;
	logic [UW+3:0] v_f;
	logic [UW:0]   bl_f, bh_f;
	logic          over_f;

	logic [UW-1:0] y_s6;

	always_comb begin
		case (mode_q) inside
			ece_pkg::MODE_CUBIC_IN, ece_pkg::MODE_CUBIC_OUT,
			ece_pkg::MODE_CUBIC_INOUT: begin
				pn_f = p3_s5;
				v_f  = {4'b0000, pn_f} << 2;
			end
			ece_pkg::MODE_QUINT_IN, ece_pkg::MODE_QUINT_OUT,
			ece_pkg::MODE_QUINT_INOUT: begin
				pn_f = p5_s5;
				v_f  = {4'b0000, pn_f} << 4;
			end
			default: begin
				pn_f = p2_s5;
				v_f  = {4'b0000, pn_f} << 1;
			end
		endcase
		over_f = (v_f > {4'b0000, ONE});
		bl_f   = ({1'b0, ONE} - {1'b0, by_s5} + (UW+1)'(1)) >> 1;
		bh_f   = ({1'b0, by_s5} + {1'b0, ONE} + (UW+1)'(1)) >> 1;
		case (mode_q) inside
			ece_pkg::MODE_QUAD_IN, ece_pkg::MODE_CUBIC_IN,
			ece_pkg::MODE_QUINT_IN:     y_f = pn_f;
			ece_pkg::MODE_QUAD_OUT, ece_pkg::MODE_CUBIC_OUT,
			ece_pkg::MODE_QUINT_OUT:    y_f = ONE - pn_f;
			ece_pkg::MODE_QUAD_INOUT, ece_pkg::MODE_CUBIC_INOUT,
			ece_pkg::MODE_QUINT_INOUT: begin
				if (lo_s5) begin
					y_f = over_f ? ONE : v_f[UW-1:0];
				end else begin
					y_f = over_f ? '0 : (ONE - v_f[UW-1:0]);
				end
			end
			ece_pkg::MODE_BOUNCE_IN:    y_f = ONE - by_s5;
			ece_pkg::MODE_BOUNCE_OUT:   y_f = by_s5;
			ece_pkg::MODE_BOUNCE_INOUT: y_f = lo_s5 ? bl_f[UW-1:0] : bh_f[UW-1:0];
			default:                    y_f = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (go[SF]) begin
			y_s6 <= y_f;
		end
	end

	// ---------------------------------------------------- stage 7: scale
	logic signed [PW-1:0] prod_s7;

	always_ff @(posedge clk) begin
		if (go[SG]) begin
			prod_s7 <= $signed({{(PW-VALUE_BITS){change_q[VALUE_BITS-1]}}, change_q}) *
				$signed({{(PW-UW){1'b0}}, y_s6});
		end
	end

	// ------------------------------------------ stage 8: round, offset, clip
	logic signed [PW-1:0]     rsum_h;
	logic signed [RW-1:0]     res_h;
	logic signed [RW-1:0]     lim_hi, lim_lo;
	logic signed [VALUE_BITS:0] val_h;

	logic signed [VALUE_BITS:0] value_s8;
	logic                       bad_s8;

	always_comb begin
		rsum_h = prod_s7 + $signed({{(PW-UW){1'b0}}, HALF});
		res_h  = $signed({{2{start_q[VALUE_BITS-1]}}, start_q}) + rsum_h[PW-1:F];
		lim_hi = $signed({2'b00, {VALUE_BITS{1'b1}}});
		lim_lo = $signed({2'b11, {VALUE_BITS{1'b0}}});
		if (duration_q == '0) begin
			val_h = $signed({start_q[VALUE_BITS-1], start_q});
		end else if (res_h > lim_hi) begin
			val_h = lim_hi[VALUE_BITS:0];
		end else if (res_h < lim_lo) begin
			val_h = lim_lo[VALUE_BITS:0];
		end else begin
			val_h = res_h[VALUE_BITS:0];
		end
	end

	always_ff @(posedge clk) begin
		if (go[SH]) begin
			value_s8 <= val_h;
			bad_s8   <= (duration_q == '0);
		end
	end

	assign eased_value  = value_s8;
	assign bad_duration = bad_s8;

endmodule

`default_nettype wire

>>> rtl/ece_checker.sv
// ----------------------------------------------------------------------------
// ece_checker
// Port-level checks of the easing curve evaluator: output hold under stall,
// reset, and the zero-duration result against shadowed configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module ece_checker #(
	parameter int VALUE_BITS = ece_pkg::VALUE_BITS
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             wr_en,
	input wire logic [ece_pkg::INDEX_BITS-1:0]   wr_index,
	input wire logic [((VALUE_BITS > ece_pkg::TIME_BITS) ?
		VALUE_BITS : ece_pkg::TIME_BITS)-1:0] wr_data,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic signed [VALUE_BITS:0]       eased_value,
	input wire logic                             bad_duration
);

	logic [VALUE_BITS-1:0] start_q;
	logic                  zero_dur_q;

	// shadow the registers that fix the zero-duration result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			zero_dur_q <= 1'b0;
		end else if (wr_en) begin
			if (wr_index == ece_pkg::REG_START) begin
				start_q <= wr_data[VALUE_BITS-1:0];
			end
			if (wr_index == ece_pkg::REG_DURATION) begin
				zero_dur_q <= (wr_data[ece_pkg::TIME_BITS-1:0] == '0);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(eased_value) &&
		$stable(bad_duration))
		else $error("result word changed while stalled");

	// valid bits are cleared asynchronously while reset is asserted
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bad_duration == zero_dur_q)
		else $error("zero-duration flag disagrees with duration");

	a_zero_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_duration |->
		eased_value == $signed({start_q[VALUE_BITS-1], start_q}))
		else $error("zero-duration result is not the start value");

endmodule

bind easing_curve_evaluator ece_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_ece_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.wr_en        (wr_en),
	.wr_index     (wr_index),
	.wr_data      (wr_data),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.eased_value  (eased_value),
	.bad_duration (bad_duration)
);

`default_nettype wire

>>> bench/easing_curve_checker.sv
// ----------------------------------------------------------------------------
// easing_curve_checker
// Watches the time step and result channels of the easing curve evaluator,
// predicts each eased value from a shadow copy of the registers and compares
// results in order. Hands the number of mismatches to the bench top.
// ----------------------------------------------------------------------------
`default_nettype none

module easing_curve_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [ece_pkg::INDEX_BITS-1:0]     wr_index,
	input  wire logic [15:0]                        wr_data,
	input  wire logic                               in_valid,
	input  wire logic                               in_ready,
	input  wire logic [15:0]                        time_step,
	input  wire logic                               out_valid,
	input  wire logic                               out_ready,
	input  wire logic signed [16:0]                 eased_value,
	input  wire logic                               bad_duration,
	output int                                      mismatches,
	output int                                      pending
);
	import ece_pkg::*;

	localparam longint ONE  = 64'd1 << FRAC_BITS;
	localparam longint HALF = 64'd1 << (FRAC_BITS - 1);

	typedef struct {
		logic signed [16:0] value;
		logic               bad;
	} eased_word_t;

	logic [3:0]         mode_q;
	logic signed [15:0] start_q;
	logic signed [15:0] change_q;
	logic [15:0]        duration_q;
	eased_word_t        expected_words[$];

	function automatic longint mul_round(longint a, longint b);
		return (a * b + HALF) >>> FRAC_BITS;
	endfunction

	function automatic longint power_q(longint x, int n);
		longint p;
		p = x;
		for (int i = 1; i < n; i++)
			p = mul_round(p, x);
		return p;
	endfunction

	function automatic longint square_shift(longint m, int sh);
		longint a;
		a = (m < 0) ? -m : m;
		return (a * a + (64'd1 << (sh - 1))) >>> sh;
	endfunction

	function automatic longint bounce(longint x);
		longint x11, y;
		x11 = 11 * x;
		if (x11 < 4 * ONE)
			y = square_shift(x11, FRAC_BITS + 4);
		else if (x11 < 8 * ONE)
			y = square_shift(x11 - 6 * ONE, FRAC_BITS + 4) + 3 * (ONE >> 2);
		else if (x11 < 10 * ONE)
			y = square_shift(x11 - 9 * ONE, FRAC_BITS + 4) + 15 * (ONE >> 4);
		else
			y = square_shift(2 * x11 - 21 * ONE, FRAC_BITS + 6) + 63 * (ONE >> 6);
		return (y > ONE) ? ONE : y;
	endfunction

	function automatic longint poly(longint u, int n, int kind);
		longint v, gain;
		gain = 64'd1 << (n - 1);
		if (kind == 0)
			return power_q(u, n);
		if (kind == 1)
			return ONE - power_q(ONE - u, n);
		if (u < HALF) begin
			v = gain * power_q(u, n);
			return (v > ONE) ? ONE : v;
		end
		v = gain * power_q(ONE - u, n);
		return (v > ONE) ? 0 : ONE - v;
	endfunction

	function automatic longint curve_at(logic [3:0] mode, longint u);
		case (mode)
			MODE_QUAD_IN, MODE_QUAD_OUT, MODE_QUAD_INOUT: begin
				return poly(u, 2, int'(mode - MODE_QUAD_IN));
			end
			MODE_CUBIC_IN, MODE_CUBIC_OUT, MODE_CUBIC_INOUT: begin
				return poly(u, 3, int'(mode - MODE_CUBIC_IN));
			end
			MODE_QUINT_IN, MODE_QUINT_OUT, MODE_QUINT_INOUT: begin
				return poly(u, 5, int'(mode - MODE_QUINT_IN));
			end
			MODE_BOUNCE_IN: return ONE - bounce(ONE - u);
			MODE_BOUNCE_OUT: return bounce(u);
			MODE_BOUNCE_INOUT: begin
				if (2 * u < ONE)
					return (ONE - bounce(ONE - 2 * u) + 1) >>> 1;
				return (bounce(2 * u - ONE) + ONE + 1) >>> 1;
			end
			default: return 0;
		endcase
	endfunction

	function automatic eased_word_t ease(logic [15:0] step);
		eased_word_t w;
		longint t, u, res;
		w.bad = (duration_q == 0);
		if (w.bad) begin
			res = start_q;
		end else begin
			t = (step > duration_q) ? duration_q : step;
			u = (t << FRAC_BITS) / duration_q;
			// >>> on a signed longint floors, as the rounding needs
			res = start_q + ((change_q * curve_at(mode_q, u) + HALF) >>> FRAC_BITS);
		end
		if (res < -65536)
			res = -65536;
		if (res > 65535)
			res = 65535;
		w.value = res[16:0];
		return w;
	endfunction

	task automatic report(string what, logic [16:0] got, logic [16:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		eased_word_t want;
		if (!arst_n) begin
			mode_q <= MODE_QUAD_IN;
			start_q <= '0;
			change_q <= '0;
			duration_q <= 16'd1;
		end else begin
			if (in_valid && in_ready)
				expected_words.push_back(ease(time_step));
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report("unexpected word", eased_value, '0);
				end else begin
					want = expected_words.pop_front();
					if (eased_value !== want.value)
						report("eased_value", eased_value, want.value);
					if (bad_duration !== want.bad)
						report("bad_duration", bad_duration, want.bad);
				end
			end
			pending = expected_words.size();
			if (wr_en) begin
				case (wr_index)
					REG_MODE: mode_q <= wr_data[3:0];
					REG_START: start_q <= wr_data;
					REG_CHANGE: change_q <= wr_data;
					default: duration_q <= wr_data;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> bench/easing_curve_evaluator_tb.sv
// ----------------------------------------------------------------------------
// easing_curve_evaluator_tb
// Drives time steps through every curve under several register settings,
// with random gaps and stalls on both channels, and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module easing_curve_evaluator_tb;
	import ece_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int DRAIN    = 40;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [1:0]         wr_index = REG_MODE;
	logic [15:0]        wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [15:0]        time_step = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [16:0] eased_value;
	logic               bad_duration;
	int                 mismatches;
	int                 pending;
	int                 idle_cycles = 0;
	bit                 long_hold = 1'b0;
	bit                 stimulus_done = 1'b0;

	always #4 clk = ~clk;

	easing_curve_evaluator i_dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .in_valid(in_valid), .in_ready(in_ready),
		.time_step(time_step), .out_valid(out_valid), .out_ready(out_ready),
		.eased_value(eased_value), .bad_duration(bad_duration)
	);

	easing_curve_checker i_checker (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .in_valid(in_valid), .in_ready(in_ready),
		.time_step(time_step), .out_valid(out_valid), .out_ready(out_ready),
		.eased_value(eased_value), .bad_duration(bad_duration),
		.mismatches(mismatches), .pending(pending)
	);

	function automatic int gap_length();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	// the enable is dropped by the next word sent
	task automatic write_reg(logic [1:0] index, logic [15:0] data);
		wr_en <= 1'b1;
		wr_index <= index;
		wr_data <= data;
		@(posedge clk);
	endtask

	// wait for every result, then let the pipeline settle before a write
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// valid stays high into the next word unless a gap is taken
	task automatic send_word(logic [15:0] step, bit gaps);
		int gap;
		gap = gaps ? gap_length() : 0;
		wr_en <= 1'b0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		time_step <= step;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_burst(int count, logic [15:0] dur);
		logic [15:0] step;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: step = 16'd0;
				1: step = dur;
				2: step = 16'hFFFF;
				3: step = $urandom;
				default: step = (dur == 0) ? $urandom : $urandom_range(0, dur);
			endcase
			send_word(step, 1'b1);
		end
	endtask

	// receiver: random stalls, or one long hold while the sender keeps going
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
				if (gap != 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n || stimulus_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired");
			$display("** easing_curve_evaluator: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [15:0] dur;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: duration 1, all zero
		send_word(16'd0, 1'b0);
		send_word(16'd1, 1'b0);
		drain();

		// directed: full swing, every mode at the ends and middle
		write_reg(REG_START, 16'h8000);
		write_reg(REG_CHANGE, 16'h7FFF);
		write_reg(REG_DURATION, 16'hFFFF);
		for (int m = 0; m < 16; m++) begin
			write_reg(REG_MODE, m[3:0]);
			send_word(16'd0, 1'b0);
			send_word(16'h7FFF, 1'b0);
			send_word(16'hFFFF, 1'b0);
			drain();
		end
		write_reg(REG_MODE, MODE_BOUNCE_INOUT);
		write_reg(REG_START, 16'h7FFF);
		write_reg(REG_CHANGE, 16'h8000);
		write_reg(REG_DURATION, 16'd0);
		send_word(16'd5, 1'b0);
		send_word(16'hFFFF, 1'b0);
		drain();
		write_reg(REG_DURATION, 16'd11);
		for (int s = 0; s <= 12; s++)
			send_word(s[15:0], 1'b0);
		drain();

		// random phases
		for (int phase = 0; phase < 40; phase++) begin
			write_reg(REG_MODE, $urandom_range(0, 15));
			write_reg(REG_START, $urandom);
			write_reg(REG_CHANGE, $urandom);
			case ($urandom_range(0, 5))
				0: dur = 16'd0;
				1: dur = 16'hFFFF;
				2: dur = $urandom_range(1, 20);
				default: dur = $urandom;
			endcase
			write_reg(REG_DURATION, dur);
			if (phase == 10)
				long_hold = 1'b1;
			send_burst(40, dur);
			if (phase % 8 == 3) begin
				// pause until the pipeline is empty
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			drain();
		end
		stimulus_done = 1'b1;

		if (mismatches == 0)
			$display("** easing_curve_evaluator: PASSED **");
		else
			$display("** easing_curve_evaluator: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
rtl/ece_pkg.sv
rtl/easing_curve_evaluator.sv
rtl/ece_checker.sv
bench/easing_curve_checker.sv
bench/easing_curve_evaluator_tb.sv
